// ===== rtl/pps_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Preemptive priority scheduler package
// Shared sizes and state codes for the scheduler block.
// ----------------------------------------------------------------------------
package pps_pkg;

	// Table depth and derived index and count widths.
	localparam int MAX_PROCS = 16;
	localparam int IDX_W     = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
	localparam int CNT_W     = $clog2(MAX_PROCS + 1);

	// Field widths.
	localparam int TIME_W  = 16;
	localparam int PRI_W   = 8;
	localparam int TICK_W  = 21;
	localparam int PIDX_W  = 6;
	localparam int STATE_W = 2;

	// Sequencer state codes.
	localparam logic [STATE_W-1:0] ST_IDLE = 2'd0;
	localparam logic [STATE_W-1:0] ST_SCAN = 2'd1;
	localparam logic [STATE_W-1:0] ST_STEP = 2'd2;
	localparam logic [STATE_W-1:0] ST_EMIT = 2'd3;

	typedef logic [TICK_W-1:0] tick_t;

endpackage

// ===== rtl/preemptive_priority_scheduler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Preemptive priority scheduler
// Loads a set of processes and schedules them in unit ticks, then reports
// completion, turnaround and waiting time for each process in load order.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid / in_stall) takes one process per transaction.
// An item without last_process is written into the tables and in_stall stays low,
// so processes can be loaded back to back. An item with last_process starts
// the schedule, and in_stall stays high until the last result has been
// placed in the output register. Items beyond the table depth are dropped.
// Each simulated tick is one scan of the loaded entries by a single shared
// compare unit, one entry per cycle, followed by one update step in the STEP
// state, which then advances the tick. An idle gap is skipped in one such
// pass. Results then leave at one per cycle on out_valid / out_stall; while
// the receiver stalls, the output register holds its transaction and the
// sequencer waits. The configuration channel (cfg_valid / cfg_ready) is
// always ready and writes larger_value_wins. Reset clears the sequencer,
// the counters and the configuration; the tables need no clearing.
// ----------------------------------------------------------------------------
module preemptive_priority_scheduler
	import pps_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	// Configuration write channel.
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic                larger_value_wins,
	// Input channel.
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [TIME_W-1:0]   arrival_time,
	input  logic [TIME_W-1:0]   burst_time,
	input  logic [PRI_W-1:0]    priority_value,
	input  logic                last_process,
	// Output channel.
	output logic                out_valid,
	input  logic                out_stall,
	output logic [PIDX_W-1:0]   process_index,
	output logic [TICK_W-1:0]   completion_time,
	output logic [TICK_W-1:0]   turnaround_time,
	output logic [TICK_W-1:0]   waiting_time,
	output logic                last_result
);

	// Process tables.
	logic [TIME_W-1:0] arrival_mem   [MAX_PROCS];
	logic [TIME_W-1:0] burst_mem     [MAX_PROCS];
	logic [PRI_W-1:0]  priority_mem  [MAX_PROCS];
	logic [TIME_W-1:0] remaining_mem [MAX_PROCS];
	tick_t             finish_mem    [MAX_PROCS];

	// Control state.
	logic [STATE_W-1:0] state_q;
	logic               larger_q;
	logic [CNT_W-1:0]   loaded_q;
	logic [CNT_W-1:0]   done_q;
	tick_t              tick_q;
	logic [IDX_W-1:0]   scan_q;

	// Scan results.
	logic               found_q;
	logic [IDX_W-1:0]   best_idx_q;
	logic [PRI_W-1:0]   best_pri_q;
	logic [TIME_W-1:0]  best_rem_q;
	logic [TIME_W-1:0]  min_arr_q;

	// Output register.
	logic               out_valid_q;
	logic [PIDX_W-1:0]  pidx_q;
	tick_t              ct_q;
	tick_t              tat_q;
	tick_t              wt_q;
	logic               last_q;

	logic               in_take;
	logic               has_room;
	logic [IDX_W-1:0]   load_idx;
	logic [CNT_W-1:0]   scan_next;
	logic               scan_last;
	logic               ent_pending;
	logic               ent_ready;
	logic               ent_better;
	logic               out_free;
	tick_t              ent_tat;
	tick_t              tick_inc;
	logic [CNT_W-1:0]   done_inc;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != ST_IDLE);
	assign in_take   = in_valid && !in_stall;
	assign has_room  = (loaded_q < CNT_W'(MAX_PROCS));
	assign load_idx  = loaded_q[IDX_W-1:0];
	assign out_free  = !out_valid_q || !out_stall;

	// Shared compare unit: one table entry per cycle against the running best.
	assign scan_next   = CNT_W'(scan_q) + CNT_W'(1);
	assign scan_last   = (scan_next == loaded_q);
	assign ent_pending = (remaining_mem[scan_q] != '0);
	assign ent_ready   = ent_pending && (TICK_W'(arrival_mem[scan_q]) <= tick_q);
	assign ent_better  = !found_q ||
		(larger_q ? (priority_mem[scan_q] >= best_pri_q)
		          : (priority_mem[scan_q] <  best_pri_q));

	assign tick_inc = tick_q + TICK_W'(1);
	assign done_inc = done_q + CNT_W'(1);

	// Turnaround of the entry being reported.
	assign ent_tat = finish_mem[scan_q] - TICK_W'(arrival_mem[scan_q]);

	// Table writes: loading and the per-tick update.
	always_ff @(posedge clk) begin
		if (in_take && has_room) begin
			arrival_mem[load_idx]   <= arrival_time;
			burst_mem[load_idx]     <= burst_time;
			priority_mem[load_idx]  <= priority_value;
			remaining_mem[load_idx] <= (burst_time == '0) ? TIME_W'(1) : burst_time;
		end
		if (state_q == ST_STEP && found_q) begin
			remaining_mem[best_idx_q] <= best_rem_q - TIME_W'(1);
			if (best_rem_q == TIME_W'(1)) begin
				finish_mem[best_idx_q] <= tick_inc;
			end
		end
	end

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			larger_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			larger_q <= larger_value_wins;
		end
	end

	// Sequencer: load, scan, step, emit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			loaded_q <= '0;
			done_q   <= '0;
			tick_q   <= '0;
			scan_q   <= '0;
			found_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						if (has_room) begin
							loaded_q <= loaded_q + CNT_W'(1);
						end
						if (last_process) begin
							state_q <= ST_SCAN;
							tick_q  <= '0;
							done_q  <= '0;
							scan_q  <= '0;
							found_q <= 1'b0;
						end
					end
				end
				ST_SCAN: begin
					if (ent_ready && ent_better) begin
						found_q <= 1'b1;
					end
					if (scan_last) begin
						state_q <= ST_STEP;
					end else begin
						scan_q <= scan_next[IDX_W-1:0];
					end
				end
				ST_STEP: begin
					scan_q  <= '0;
					found_q <= 1'b0;
					if (found_q) begin
						tick_q <= tick_inc;
						if (best_rem_q == TIME_W'(1)) begin
							done_q <= done_inc;
						end
						if (best_rem_q == TIME_W'(1) && done_inc == loaded_q) begin
							state_q <= ST_EMIT;
						end else begin
							state_q <= ST_SCAN;
						end
					end else begin
						// Nothing ready: jump to the earliest pending arrival.
						tick_q  <= TICK_W'(min_arr_q);
						state_q <= ST_SCAN;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						if (scan_last) begin
							state_q  <= ST_IDLE;
							loaded_q <= '0;
							done_q   <= '0;
							tick_q   <= '0;
						end else begin
							scan_q <= scan_next[IDX_W-1:0];
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Running best and earliest pending arrival during a scan.
	always_ff @(posedge clk) begin
		if (state_q == ST_STEP || state_q == ST_IDLE) begin
			min_arr_q <= '1;
		end else if (state_q == ST_SCAN) begin
			if (ent_ready && ent_better) begin
				best_idx_q <= scan_q;
				best_pri_q <= priority_mem[scan_q];
				best_rem_q <= remaining_mem[scan_q];
			end
			if (ent_pending && arrival_mem[scan_q] < min_arr_q) begin
				min_arr_q <= arrival_mem[scan_q];
			end
		end
	end

	// Output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_EMIT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload: one result transaction per process in index order.
	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT && out_free) begin
			pidx_q <= PIDX_W'(scan_q);
			ct_q   <= finish_mem[scan_q];
			tat_q  <= ent_tat;
			wt_q   <= ent_tat - TICK_W'(burst_mem[scan_q]);
			last_q <= scan_last;
		end
	end

	assign out_valid       = out_valid_q;
	assign process_index   = pidx_q;
	assign completion_time = ct_q;
	assign turnaround_time = tat_q;
	assign waiting_time    = wt_q;
	assign last_result     = last_q;

	// The load count never exceeds the table depth.
	a_loaded_bound: assert property (@(posedge clk) disable iff (!arst_n)
		loaded_q <= CNT_W'(MAX_PROCS))
		else $error("loaded count above table depth");

	// Finished processes never outnumber loaded ones.
	a_done_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done_q <= loaded_q)
		else $error("done count above loaded count");

	// A new result only comes out of the emit phase.
	a_emit_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_EMIT))
		else $error("result raised outside emit phase");

	// Running a process advances time by exactly one tick.
	a_tick_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_STEP && found_q) |=> (tick_q == $past(tick_inc)))
		else $error("tick did not advance by one");

	// Scheduling never starts with an empty set.
	a_scan_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (loaded_q != '0))
		else $error("scan with no loaded process");

endmodule

// ===== tb/preemptive_priority_scheduler_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Preemptive priority scheduler checker
// Watches the configuration, input and output channels of the scheduler,
// keeps its own copy of the process tables, schedules each completed set in
// unit ticks and compares every reported process with the oldest prediction.
// ----------------------------------------------------------------------------
module preemptive_priority_scheduler_checker
	import pps_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	input  logic              cfg_ready,
	input  logic              larger_value_wins,
	input  logic              in_valid,
	input  logic              in_stall,
	input  logic [TIME_W-1:0] arrival_time,
	input  logic [TIME_W-1:0] burst_time,
	input  logic [PRI_W-1:0]  priority_value,
	input  logic              last_process,
	input  logic              out_valid,
	input  logic              out_stall,
	input  logic [PIDX_W-1:0] process_index,
	input  logic [TICK_W-1:0] completion_time,
	input  logic [TICK_W-1:0] turnaround_time,
	input  logic [TICK_W-1:0] waiting_time,
	input  logic              last_result,
	output int                mismatches,
	output int                reports_pending
);

	// One predicted report for a finished process.
	typedef struct {
		logic [PIDX_W-1:0] pidx;
		tick_t             completion;
		tick_t             turnaround;
		tick_t             waiting;
		logic              last;
	} proc_report_t;

	proc_report_t      report_q[$];
	logic              prefer_larger = 1'b0;
	logic [TIME_W-1:0] arr_tab   [MAX_PROCS];
	logic [TIME_W-1:0] burst_tab [MAX_PROCS];
	logic [PRI_W-1:0]  pri_tab   [MAX_PROCS];
	int unsigned       loaded_procs = 0;
	int                error_total = 0;

	// Compares one field of a reported process and counts a difference.
	function automatic void check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			error_total++;
		end
	endfunction

	// Runs the loaded set tick by tick and queues one report per process.
	task automatic schedule_set(input int unsigned n);
		int unsigned  left [MAX_PROCS];
		tick_t        done_at [MAX_PROCS];
		tick_t        tick;
		int unsigned  finished;
		int unsigned  next_arr;
		int unsigned  best_pri;
		int           best;
		proc_report_t rep;
		for (int k = 0; k < n; k++)
			left[k] = (burst_tab[k] == 0) ? 1 : burst_tab[k];
		tick = '0;
		finished = 0;
		while (finished < n) begin
			// Pick the best ready process; ties follow the comparison direction.
			best = -1;
			best_pri = 0;
			for (int k = 0; k < n; k++) begin
				if (left[k] != 0 && arr_tab[k] <= tick) begin
					if (best < 0 || (prefer_larger ? (pri_tab[k] >= best_pri)
					                               : (pri_tab[k] < best_pri))) begin
						best = k;
						best_pri = pri_tab[k];
					end
				end
			end
			if (best < 0) begin
				// Nothing is ready, so time jumps to the earliest pending arrival.
				next_arr = 32'hFFFF_FFFF;
				for (int k = 0; k < n; k++)
					if (left[k] != 0 && arr_tab[k] < next_arr)
						next_arr = arr_tab[k];
				tick = tick_t'(next_arr);
			end else begin
				left[best]--;
				tick = tick + 1'b1;
				if (left[best] == 0) begin
					done_at[best] = tick;
					finished++;
				end
			end
		end
		for (int k = 0; k < n; k++) begin
			rep.pidx       = PIDX_W'(k);
			rep.completion = done_at[k];
			rep.turnaround = done_at[k] - tick_t'(arr_tab[k]);
			rep.waiting    = rep.turnaround - tick_t'(burst_tab[k]);
			rep.last       = (k + 1 == n);
			report_q.push_back(rep);
		end
	endtask

	// Follows every transaction on the three channels.
	always @(posedge clk or negedge arst_n) begin
		proc_report_t want;
		if (!arst_n) begin
			prefer_larger = 1'b0;
			loaded_procs = 0;
			report_q.delete();
			reports_pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				prefer_larger = larger_value_wins;

			// Compare each accepted result with the oldest prediction.
			if (out_valid && !out_stall) begin
				if (report_q.size() == 0) begin
					$error("unexpected result for process %0d", process_index);
					error_total++;
				end else begin
					want = report_q.pop_front();
					check_field("process_index", want.pidx, process_index);
					check_field("completion_time", want.completion, completion_time);
					check_field("turnaround_time", want.turnaround, turnaround_time);
					check_field("waiting_time", want.waiting, waiting_time);
					check_field("last_result", want.last, last_result);
				end
			end

			// Store the process if there is room; the last one starts the schedule.
			if (in_valid && !in_stall) begin
				if (loaded_procs < MAX_PROCS) begin
					arr_tab[loaded_procs]   = arrival_time;
					burst_tab[loaded_procs] = burst_time;
					pri_tab[loaded_procs]   = priority_value;
					loaded_procs++;
				end
				if (last_process) begin
					schedule_set(loaded_procs);
					loaded_procs = 0;
				end
			end
			reports_pending <= report_q.size();
		end
		mismatches <= error_total;
	end

endmodule

// ===== tb/preemptive_priority_scheduler_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Preemptive priority scheduler testbench
// Loads directed and random process sets through the input channel, flips the
// priority direction between phases, stalls the result channel in changing
// patterns and lets the checker judge every reported process.
// ----------------------------------------------------------------------------
module preemptive_priority_scheduler_tb;
	import pps_pkg::*;

	// Receiver stall patterns.
	typedef enum int {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_PERIODIC
	} stall_mode_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic              larger_value_wins = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [TIME_W-1:0] arrival_time = '0;
	logic [TIME_W-1:0] burst_time = '0;
	logic [PRI_W-1:0]  priority_value = '0;
	logic              last_process = 1'b0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [PIDX_W-1:0] process_index;
	logic [TICK_W-1:0] completion_time;
	logic [TICK_W-1:0] turnaround_time;
	logic [TICK_W-1:0] waiting_time;
	logic              last_result;
	int                mismatches;
	int                reports_pending;

	stall_mode_t       stall_mode = STALL_NONE;
	int                stall_left = 0;
	int                run_left = 0;
	logic              steady = 1'b0;

	preemptive_priority_scheduler dut (.*);

	preemptive_priority_scheduler_checker checker_i (.*);

	// Clock generation.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// The receiver switches between stall patterns at random intervals.
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= stall_mode_t'($urandom_range(0, 3));
			stall_left <= $urandom_range(32, 300);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_mode)
			STALL_NONE:  out_stall <= 1'b0;
			STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
			STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
			default:     out_stall <= stall_left[2];
		endcase
	end

	// Presents one process and waits for its transaction. The sender works in
	// bursts; a gap is inserted only when a new burst begins.
	task automatic send_proc(input logic [TIME_W-1:0] arr, input logic [TIME_W-1:0] burst,
			input logic [PRI_W-1:0] pri, input logic last);
		int gap;
		if (run_left == 0) begin
			run_left = $urandom_range(1, 12);
			gap = steady ? 0 : $urandom_range(0, 5);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		run_left--;
		in_valid       <= 1'b1;
		arrival_time   <= arr;
		burst_time     <= burst;
		priority_value <= pri;
		last_process   <= last;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	// Waits until every predicted report has arrived and the block has settled.
	task automatic wait_drained();
		@(posedge clk);
		while (reports_pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Writes the priority direction register.
	task automatic write_direction(input logic larger);
		cfg_valid         <= 1'b1;
		larger_value_wins <= larger;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Sends one random set; a few sets overflow the table.
	task automatic send_random_set(output int count);
		int   pick;
		int   spread;
		logic wide_pri;
		logic [TIME_W-1:0] arr;
		logic [TIME_W-1:0] burst;
		logic [PRI_W-1:0]  pri;
		pick = $urandom_range(0, 9);
		if (pick == 0)
			count = $urandom_range(MAX_PROCS + 1, MAX_PROCS + 4);
		else if (pick < 3)
			count = $urandom_range(9, MAX_PROCS);
		else
			count = $urandom_range(1, 8);
		pick = $urandom_range(0, 3);
		spread = (pick == 0) ? 65535 : ((pick == 1) ? 64 : 8);
		wide_pri = $urandom_range(0, 1);
		for (int i = 0; i < count; i++) begin
			arr = TIME_W'($urandom_range(0, spread));
			// Long bursts are rare since every tick costs a full scan.
			if ($urandom_range(0, 31) == 0)
				burst = TIME_W'($urandom_range(0, 255));
			else
				burst = TIME_W'($urandom_range(0, 24));
			pri = wide_pri ? PRI_W'($urandom_range(0, 255)) : PRI_W'($urandom_range(0, 3));
			send_proc(arr, burst, pri, i == count - 1);
		end
	endtask

	// Run limit.
	initial begin
		#200_000_000;
		$display("FAILED: results differ");
		$finish;
	end

	// Stimulus and verdict.
	initial begin
		int sent;
		int count;
		int phase;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_direction(1'b0);

		// A lone process with zero burst.
		send_proc('0, '0, '0, 1'b1);
		// A lone process at the latest arrival with the longest burst.
		send_proc('1, '1, '1, 1'b1);
		// A set that fills the table, with an idle gap, tied priorities and a
		// dropped last item that still starts the schedule.
		for (int k = 0; k <= MAX_PROCS; k++)
			send_proc(TIME_W'((k < 8) ? k : 200 + k), TIME_W'(k % 4),
				PRI_W'((k % 3 == 0) ? 0 : ((k == 5) ? 255 : 7)), k == MAX_PROCS);
		in_valid <= 1'b0;
		wait_drained();

		// Larger values win: ties go to the larger index.
		write_direction(1'b1);
		send_proc('0, 16'd2, 8'd9, 1'b0);
		send_proc('0, 16'd2, 8'd9, 1'b0);
		send_proc('0, 16'd2, 8'd3, 1'b0);
		send_proc(16'd1, 16'd2, 8'd9, 1'b1);
		in_valid <= 1'b0;

		// Random phases, alternating the priority direction.
		sent = 0;
		phase = 0;
		while (sent < 250) begin
			wait_drained();
			write_direction(phase % 2 == 1);
			steady = ($urandom_range(0, 3) == 0);
			repeat ($urandom_range(2, 6)) begin
				send_random_set(count);
				sent += count;
			end
			in_valid <= 1'b0;
			phase++;
		end

		wait_drained();
		repeat (20) @(posedge clk);
		if (mismatches == 0 && reports_pending == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
